// File: design/icdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, codes and types for the inverse-CDF sampler.
// No dependencies; used by the sampler top level and its checker.

package icdf_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH  = 2048;
    localparam int ADDR_BITS    = $clog2(TABLE_DEPTH);
    localparam int ENERGY_BITS  = 24;
    localparam int PROB_BITS    = 32;
    localparam int COUNT_BITS   = 12;
    localparam int BITCNT_BITS  = $clog2(ENERGY_BITS);

    // Reset value of the entries-in-use register
    localparam logic [COUNT_BITS-1:0] ENTRIES_RESET = COUNT_BITS'(TABLE_DEPTH);

    // Item function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // One stored table entry
    typedef struct packed {
        logic [ENERGY_BITS-1:0] energy;
        logic [PROB_BITS-1:0]   cumulative;
    } entry_t;

endpackage

`default_nettype wire

// File: design/icdf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module icdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/inverse_cdf_sampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Inverse-CDF sampler top level: table RAM, first-hit scan and serial multiply-divide.
// Depends on icdf_pkg and icdf_ram.
//
// Load beat: written in the accept cycle, busy never rises, no result.
// Sample beat: one RAM read per cycle scans entries from 0 until the first hit. A hit
// at entry 0 goes straight to FINISH; otherwise PREP and CHECK follow, and a degenerate
// interval then finishes, else the shared compare-subtract unit runs DIV_A and DIV_B
// once per energy bit before FINISH. A miss returns once the last of n entries is read.
// One sample at a time; done pulses one cycle and cannot be stalled.
// Reset: async active low; control idle, entries_in_use = 2048, table not cleared.

module inverse_cdf_sampler_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             func,
    input  wire logic [icdf_pkg::ADDR_BITS-1:0]   entry_index,
    input  wire logic [icdf_pkg::ENERGY_BITS-1:0] entry_energy,
    input  wire logic [icdf_pkg::PROB_BITS-1:0]   entry_cumulative,
    input  wire logic [icdf_pkg::PROB_BITS-1:0]   uniform_value,
    input  wire logic                             entries_in_use_we,
    input  wire logic [icdf_pkg::COUNT_BITS-1:0]  entries_in_use_wdata,
    output logic                                  done,
    output logic      [icdf_pkg::ENERGY_BITS-1:0] energy,
    output logic                                  found
);

    localparam int EB = icdf_pkg::ENERGY_BITS;
    localparam int PB = icdf_pkg::PROB_BITS;
    localparam int AB = icdf_pkg::ADDR_BITS;
    localparam int CB = icdf_pkg::COUNT_BITS;
    localparam int KB = icdf_pkg::BITCNT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_CHECK,
        ST_DIV_A,
        ST_DIV_B,
        ST_FINISH
    } state_t;

    // Control registers
    state_t           state_reg,   state_next;
    logic [CB-1:0]    cfg_reg;
    logic [CB-1:0]    n_reg,       n_next;
    logic [CB-1:0]    iss_reg,     iss_next;
    logic             rdv_reg,     rdv_next;
    logic [AB-1:0]    rd_idx_reg,  rd_idx_next;
    logic [KB-1:0]    cnt_reg,     cnt_next;
    logic             done_reg,    done_next;
    logic             found_reg,   found_next;
    logic [EB-1:0]    energy_reg,  energy_next;

    // Datapath registers
    logic [PB-1:0]    u_reg,       u_next;
    logic [EB-1:0]    prev_e_reg,  prev_e_next;
    logic [PB-1:0]    prev_p_reg,  prev_p_next;
    logic [EB-1:0]    ei_reg,      ei_next;
    logic [PB-1:0]    pi_reg,      pi_next;
    logic [PB-1:0]    dx_reg,      dx_next;
    logic [PB-1:0]    dp_reg,      dp_next;
    logic [EB-1:0]    b_reg,       b_next;
    logic [PB-1:0]    r_reg,       r_next;
    logic [EB-1:0]    q_reg,       q_next;
    logic             up_reg,      up_next;
    logic             guard_reg,   guard_next;

    // RAM signals
    icdf_pkg::entry_t wr_entry;
    icdf_pkg::entry_t rd_entry;
    logic             ram_we;
    logic             ram_re;
    logic             accept;

    // Shared compare-subtract unit
    logic [PB:0]      div_acc;
    logic             div_ge;
    logic [PB:0]      div_diff;

    // Final result arithmetic
    logic [EB:0]      sum_dn;
    logic [EB-1:0]    res_up;
    logic [EB-1:0]    res_dn;

    logic             last_read;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign energy = energy_reg;
    assign found  = found_reg;

    assign wr_entry.energy     = entry_energy;
    assign wr_entry.cumulative = entry_cumulative;
    assign ram_we = accept && (func == icdf_pkg::FUNC_LOAD)
                    && ({1'b0, entry_index} < (AB + 1)'(icdf_pkg::TABLE_DEPTH));
    assign ram_re = (state_reg == ST_SCAN) && (iss_reg < n_reg);

    icdf_ram #(
        .WIDTH($bits(icdf_pkg::entry_t)),
        .DEPTH(icdf_pkg::TABLE_DEPTH)
    ) u_table (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(entry_index),
        .wr_data(wr_entry),
        .rd_en  (ram_re),
        .rd_addr(iss_reg[AB-1:0]),
        .rd_data(rd_entry)
    );

    // Divider step: phase A doubles the remainder, phase B adds the dividend if the
    // current multiplier bit is set; both reduce once against the divisor
    always_comb
    begin
        if (state_reg == ST_DIV_A)
        begin
            div_acc = {r_reg, 1'b0};
        end
        else if (b_reg[EB-1])
        begin
            div_acc = {1'b0, r_reg} + {1'b0, dx_reg};
        end
        else
        begin
            div_acc = {1'b0, r_reg};
        end
        div_diff = div_acc - {1'b0, dp_reg};
        div_ge   = (div_acc >= {1'b0, dp_reg});
    end

    // Apply the quotient toward the previous energy, clamped to range
    assign sum_dn = {1'b0, ei_reg} + {1'b0, q_reg};
    assign res_up = (q_reg > ei_reg) ? '0 : (ei_reg - q_reg);
    assign res_dn = sum_dn[EB] ? {EB{1'b1}} : sum_dn[EB-1:0];

    assign last_read = (({1'b0, rd_idx_reg} + CB'(1)) == n_reg);

    // Next-state logic
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        iss_next    = iss_reg;
        rdv_next    = rdv_reg;
        rd_idx_next = rd_idx_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        energy_next = energy_reg;
        u_next      = u_reg;
        prev_e_next = prev_e_reg;
        prev_p_next = prev_p_reg;
        ei_next     = ei_reg;
        pi_next     = pi_reg;
        dx_next     = dx_reg;
        dp_next     = dp_reg;
        b_next      = b_reg;
        r_next      = r_reg;
        q_next      = q_reg;
        up_next     = up_reg;
        guard_next  = guard_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take a sample beat: saturate the entry count and start the scan
                if (accept && (func == icdf_pkg::FUNC_SAMPLE))
                begin
                    n_next     = (cfg_reg > CB'(icdf_pkg::TABLE_DEPTH))
                                 ? CB'(icdf_pkg::TABLE_DEPTH) : cfg_reg;
                    u_next     = uniform_value;
                    iss_next   = '0;
                    rdv_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue the next read while checking the one that just returned
                if (iss_reg < n_reg)
                begin
                    iss_next = iss_reg + CB'(1);
                end
                rdv_next    = (iss_reg < n_reg);
                rd_idx_next = iss_reg[AB-1:0];

                if (n_reg == '0)
                begin
                    energy_next = '0;
                    found_next  = 1'b0;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (rdv_reg)
                begin
                    if (rd_entry.cumulative >= u_reg)
                    begin
                        ei_next = rd_entry.energy;
                        pi_next = rd_entry.cumulative;
                        if (rd_idx_reg == '0)
                        begin
                            q_next     = '0;
                            up_next    = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_PREP;
                        end
                    end
                    else
                    begin
                        prev_e_next = rd_entry.energy;
                        prev_p_next = rd_entry.cumulative;
                        if (last_read)
                        begin
                            energy_next = '0;
                            found_next  = 1'b0;
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                        end
                    end
                end
            end

            ST_PREP:
            begin
                // Form the interval differences and the energy step magnitude
                dx_next    = pi_reg - u_reg;
                dp_next    = pi_reg - prev_p_reg;
                up_next    = (ei_reg >= prev_e_reg);
                b_next     = (ei_reg >= prev_e_reg) ? (ei_reg - prev_e_reg)
                                                    : (prev_e_reg - ei_reg);
                guard_next = (prev_p_reg >= pi_reg);
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                // Degenerate interval returns the hit energy unchanged
                r_next   = '0;
                q_next   = '0;
                cnt_next = KB'(EB - 1);
                if (guard_reg || (dx_reg >= dp_reg))
                begin
                    up_next    = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_DIV_A;
                end
            end

            ST_DIV_A:
            begin
                r_next     = div_ge ? div_diff[PB-1:0] : div_acc[PB-1:0];
                q_next     = {q_reg[EB-2:0], div_ge};
                state_next = ST_DIV_B;
            end

            ST_DIV_B:
            begin
                r_next = div_ge ? div_diff[PB-1:0] : div_acc[PB-1:0];
                q_next = q_reg + EB'(div_ge);
                b_next = {b_reg[EB-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next   = cnt_reg - KB'(1);
                    state_next = ST_DIV_A;
                end
            end

            ST_FINISH:
            begin
                energy_next = up_reg ? res_up : res_dn;
                found_next  = 1'b1;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cfg_reg    <= icdf_pkg::ENTRIES_RESET;
            n_reg      <= '0;
            iss_reg    <= '0;
            rdv_reg    <= 1'b0;
            rd_idx_reg <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            energy_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            if (entries_in_use_we)
            begin
                cfg_reg <= entries_in_use_wdata;
            end
            n_reg      <= n_next;
            iss_reg    <= iss_next;
            rdv_reg    <= rdv_next;
            rd_idx_reg <= rd_idx_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
            energy_reg <= energy_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        prev_e_reg <= prev_e_next;
        prev_p_reg <= prev_p_next;
        ei_reg     <= ei_next;
        pi_reg     <= pi_next;
        dx_reg     <= dx_next;
        dp_reg     <= dp_next;
        b_reg      <= b_next;
        r_reg      <= r_next;
        q_reg      <= q_next;
        up_reg     <= up_next;
        guard_reg  <= guard_next;
    end

endmodule

`default_nettype wire

// File: design/icdf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the inverse-CDF sampler, bound to the top level.
// Depends on icdf_pkg and inverse_cdf_sampler_unit.

module icdf_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic                             busy,
    input  wire logic                             func,
    input  wire logic                             done,
    input  wire logic [icdf_pkg::ENERGY_BITS-1:0] energy,
    input  wire logic                             found
);

    // A miss always reports zero energy
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (energy == '0))
        else $error("miss beat with nonzero energy");

    // A load beat completes at once and leaves the block free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == icdf_pkg::FUNC_LOAD)) |=> !busy)
        else $error("load beat made the block busy");

    // A sample beat occupies the block
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == icdf_pkg::FUNC_SAMPLE)) |=> busy)
        else $error("sample beat did not raise busy");

    // Busy drops exactly when a result beat appears
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result beat");

    // A result beat only follows a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a sample in progress");

endmodule

bind inverse_cdf_sampler_unit icdf_checker u_icdf_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .func  (func),
    .done  (done),
    .energy(energy),
    .found (found)
);

`default_nettype wire

// File: dv/tb_inverse_cdf_sampler_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for inverse_cdf_sampler_unit: directed rows, then random
// loads and draws. Depends on icdf_pkg and the sampler RTL; keeps its own table copy.

module tb_inverse_cdf_sampler_unit;

    localparam int TABLE_DEPTH   = icdf_pkg::TABLE_DEPTH;
    localparam int ADDR_BITS     = icdf_pkg::ADDR_BITS;
    localparam int ENERGY_BITS   = icdf_pkg::ENERGY_BITS;
    localparam int PROB_BITS     = icdf_pkg::PROB_BITS;
    localparam int COUNT_BITS    = icdf_pkg::COUNT_BITS;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int CFG_GAP       = 4;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_BEATS   = 290;
    localparam int DIR_ROWS      = 24;

    typedef enum logic [1:0] {ROW_LOAD, ROW_DRAW, ROW_DEPTH} row_kind_t;

    typedef struct packed {
        logic [ENERGY_BITS-1:0] energy;
        logic                   found;
    } draw_t;

    // arg is the fraction of a draw row or the depth of a depth row
    typedef struct packed {
        row_kind_t              kind;
        logic [ADDR_BITS-1:0]   idx;
        logic [ENERGY_BITS-1:0] e;
        logic [PROB_BITS-1:0]   p;
        logic [PROB_BITS-1:0]   arg;
        logic                   typed;
        draw_t                  want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // two-entry ramp, reset depth
        '{ROW_LOAD,  11'd0,    24'h000000, 32'h0000_0000, 32'h0,          1'b0, '{24'h0, 1'b0}},
        '{ROW_LOAD,  11'd1,    24'hFFFFFF, 32'hFFFF_FFFF, 32'h0,          1'b0, '{24'h0, 1'b0}},
        '{ROW_DRAW,  11'd0,    24'h0,      32'h0,         32'h0000_0000,  1'b1, '{24'h000000, 1'b1}},
        '{ROW_DRAW,  11'd0,    24'h0,      32'h0,         32'hFFFF_FFFF,  1'b1, '{24'hFFFFFF, 1'b1}},
        '{ROW_DRAW,  11'd0,    24'h0,      32'h0,         32'h8000_0000,  1'b0, '{24'h0, 1'b0}},
        // zero entries searched, then one entry that misses
        '{ROW_DEPTH, 11'd0,    24'h0,      32'h0,         32'd0,          1'b0, '{24'h0, 1'b0}},
        '{ROW_DRAW,  11'd0,    24'h0,      32'h0,         32'h0000_0000,  1'b1, '{24'h000000, 1'b0}},
        '{ROW_DEPTH, 11'd0,    24'h0,      32'h0,         32'd1,          1'b0, '{24'h0, 1'b0}},
        '{ROW_DRAW,  11'd0,    24'h0,      32'h0,         32'h0000_0001,  1'b1, '{24'h000000, 1'b0}},
        '{ROW_DRAW,  11'd0,    24'h0,      32'h0,         32'h0000_0000,  1'b1, '{24'h000000, 1'b1}},
        // depth above the table saturates; falling energy
        '{ROW_DEPTH, 11'd0,    24'h0,      32'h0,         32'd4095,       1'b0, '{24'h0, 1'b0}},
        '{ROW_LOAD,  11'd0,    24'hFFFFFF, 32'h0000_0000, 32'h0,          1'b0, '{24'h0, 1'b0}},
        '{ROW_LOAD,  11'd1,    24'h000000, 32'h8000_0000, 32'h0,          1'b0, '{24'h0, 1'b0}},
        '{ROW_DRAW,  11'd0,    24'h0,      32'h0,         32'h4000_0000,  1'b0, '{24'h0, 1'b0}},
        '{ROW_DRAW,  11'd0,    24'h0,      32'h0,         32'h8000_0000,  1'b1, '{24'h000000, 1'b1}},
        // flat step and a dip: non-monotone table
        '{ROW_LOAD,  11'd2,    24'h123456, 32'h8000_0000, 32'h0,          1'b0, '{24'h0, 1'b0}},
        '{ROW_LOAD,  11'd3,    24'hABCDEF, 32'h1000_0000, 32'h0,          1'b0, '{24'h0, 1'b0}},
        '{ROW_LOAD,  11'd4,    24'hFEDCBA, 32'hFFFF_FFFF, 32'h0,          1'b0, '{24'h0, 1'b0}},
        '{ROW_DRAW,  11'd0,    24'h0,      32'h0,         32'h9000_0000,  1'b0, '{24'h0, 1'b0}},
        '{ROW_LOAD,  11'd2047, 24'hFFFFFF, 32'hFFFF_FFFF, 32'h0,          1'b0, '{24'h0, 1'b0}},
        '{ROW_DEPTH, 11'd0,    24'h0,      32'h0,         32'd2048,       1'b0, '{24'h0, 1'b0}},
        '{ROW_DRAW,  11'd0,    24'h0,      32'h0,         32'h8000_0001,  1'b0, '{24'h0, 1'b0}},
        '{ROW_DEPTH, 11'd0,    24'h0,      32'h0,         32'd5,          1'b0, '{24'h0, 1'b0}},
        '{ROW_DRAW,  11'd0,    24'h0,      32'h0,         32'hFFFF_FFFF,  1'b1, '{24'hFEDCBA, 1'b1}}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   func;
    logic [ADDR_BITS-1:0]   entry_index;
    logic [ENERGY_BITS-1:0] entry_energy;
    logic [PROB_BITS-1:0]   entry_cumulative;
    logic [PROB_BITS-1:0]   uniform_value;
    logic                   entries_in_use_we;
    logic [COUNT_BITS-1:0]  entries_in_use_wdata;
    logic                   done;
    logic [ENERGY_BITS-1:0] energy;
    logic                   found;

    // Shadow of the block: table, written flags and depth register
    logic [ENERGY_BITS-1:0] bin_energy [TABLE_DEPTH];
    logic [PROB_BITS-1:0]   bin_cdf    [TABLE_DEPTH];
    bit                     bin_loaded [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]  scan_count;
    draw_t                  pending_draws [$];

    // Per-episode table plan
    logic [ENERGY_BITS-1:0] plan_energy [TABLE_DEPTH];
    logic [PROB_BITS-1:0]   plan_cdf    [TABLE_DEPTH];

    int    send_idle_pct;
    int    mismatches;
    int    beats_sent;
    int    loads_sent;
    int    draws_sent;
    int    hits_predicted;
    int    misses_predicted;
    int    depth_writes;
    int    results_seen;
    int    cycle_count;
    draw_t got_want;

    inverse_cdf_sampler_unit uut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .func                 (func),
        .entry_index          (entry_index),
        .entry_energy         (entry_energy),
        .entry_cumulative     (entry_cumulative),
        .uniform_value        (uniform_value),
        .entries_in_use_we    (entries_in_use_we),
        .entries_in_use_wdata (entries_in_use_wdata),
        .done                 (done),
        .energy               (energy),
        .found                (found)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d draws outstanding",
                     cycle_count, pending_draws.size());
            $display("FAIL");
            $finish;
        end
    end

    // Number of entries a draw searches, saturated at the table depth
    function automatic int scan_limit();
        return (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_count);
    endfunction

    // Expected result of a draw against the current shadow table
    function automatic draw_t predict_draw(input logic [PROB_BITS-1:0] u);
        int                     n;
        int                     hit_at;
        logic [63:0]            dx;
        logic [63:0]            dp;
        logic [63:0]            mag;
        logic [63:0]            q;
        logic [63:0]            sum;
        logic [ENERGY_BITS-1:0] ei;
        logic [ENERGY_BITS-1:0] ep;
        draw_t                  r;
        n = scan_limit();
        hit_at = -1;
        r = '0;
        for (int i = 0; i < n && hit_at < 0; i++)
        begin
            if (bin_cdf[i] >= u)
                hit_at = i;
        end
        if (hit_at == 0)
        begin
            r.energy = bin_energy[0];
            r.found = 1'b1;
        end
        else if (hit_at > 0)
        begin
            r.found = 1'b1;
            ei = bin_energy[hit_at];
            ep = bin_energy[hit_at-1];
            dx = 64'(bin_cdf[hit_at]) - 64'(u);
            dp = 64'(bin_cdf[hit_at]) - 64'(bin_cdf[hit_at-1]);
            // degenerate interval keeps the bin energy
            if (bin_cdf[hit_at-1] >= bin_cdf[hit_at] || dx >= dp)
                r.energy = ei;
            else
            begin
                mag = (ei >= ep) ? 64'(ei - ep) : 64'(ep - ei);
                q = (dx * mag) / dp;
                if (ei >= ep)
                    r.energy = (q > 64'(ei)) ? '0 : ei - q[ENERGY_BITS-1:0];
                else
                begin
                    sum = 64'(ei) + q;
                    r.energy = (sum > 64'({ENERGY_BITS{1'b1}})) ? '1 : sum[ENERGY_BITS-1:0];
                end
            end
        end
        return r;
    endfunction

    // True when the search for u stops before any entry never loaded
    function automatic bit draw_is_safe(input logic [PROB_BITS-1:0] u);
        int n;
        n = scan_limit();
        for (int i = 0; i < n; i++)
        begin
            if (!bin_loaded[i])
                return 1'b0;
            if (bin_cdf[i] >= u)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    // Drive one beat, hold it until accepted, then advance the shadow
    task automatic issue_beat(input logic fn, input logic [ADDR_BITS-1:0] idx,
                              input logic [ENERGY_BITS-1:0] e, input logic [PROB_BITS-1:0] p,
                              input logic [PROB_BITS-1:0] u, input bit typed, input draw_t want);
        draw_t expd;
        @(negedge clk);
        start <= 1'b1;
        func <= fn;
        entry_index <= idx;
        entry_energy <= e;
        entry_cumulative <= p;
        uniform_value <= u;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        beats_sent++;
        if (fn == icdf_pkg::FUNC_LOAD)
        begin
            bin_energy[idx] = e;
            bin_cdf[idx] = p;
            bin_loaded[idx] = 1'b1;
            loads_sent++;
        end
        else
        begin
            expd = typed ? want : predict_draw(u);
            if (expd.found)
                hits_predicted++;
            else
                misses_predicted++;
            pending_draws = {pending_draws, expd};
            draws_sent++;
        end
    endtask

    // Hold start low for a random number of cycles
    task automatic idle_gap();
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Drop start, wait out every draw in flight and let the block settle
    task automatic drain_block();
        @(negedge clk);
        start <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        do
        begin
            @(posedge clk);
        end
        while (busy);
        repeat (CFG_GAP) @(posedge clk);
    endtask

    // Write the depth register while idle
    task automatic write_depth(input logic [COUNT_BITS-1:0] depth);
        drain_block();
        @(negedge clk);
        entries_in_use_we <= 1'b1;
        entries_in_use_wdata <= depth;
        @(negedge clk);
        entries_in_use_we <= 1'b0;
        scan_count = depth;
        depth_writes++;
    endtask

    // One random episode: pick a depth, load a table, draw from it
    task automatic run_episode();
        int                    m;
        int                    r;
        int                    j;
        int                    k;
        int                    e_mode;
        int                    reach;
        bit                    sorted_p;
        bit                    reversed;
        logic [63:0]           acc;
        logic [63:0]           step_max;
        logic [63:0]           ea;
        logic [63:0]           e_step;
        logic [63:0]           delta;
        logic [PROB_BITS-1:0]  u;
        logic [PROB_BITS-1:0]  lo;
        logic [PROB_BITS-1:0]  hi;
        logic [PROB_BITS-1:0]  top;
        logic [COUNT_BITS-1:0] depth;

        // mostly small tables, a few large ones
        r = $urandom_range(0, 99);
        if (r < 74)
            m = $urandom_range(1, 16);
        else if (r < 96)
            m = $urandom_range(17, 96);
        else
            m = $urandom_range(97, 400);

        r = $urandom_range(0, 99);
        if (r < 40)
            depth = COUNT_BITS'(m);
        else if (r < 52)
            depth = COUNT_BITS'(m + $urandom_range(1, 64));
        else if (r < 60)
            depth = '1;
        else if (r < 68)
            depth = COUNT_BITS'(TABLE_DEPTH);
        else if (r < 76)
            depth = COUNT_BITS'($urandom_range(0, m - 1));
        else if (r < 84)
            depth = COUNT_BITS'($urandom_range(TABLE_DEPTH + 1, 4094));
        else
            depth = COUNT_BITS'($urandom_range(0, 4095));
        write_depth(depth);

        // cumulative column: sorted with flat steps, or scrambled
        sorted_p = ($urandom_range(0, 99) < 85);
        acc = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(0, 32'h00FF_FFFF));
        step_max = (64'h2_0000_0000 / m > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF
                                                         : 64'h2_0000_0000 / m;
        for (j = 0; j < m; j++)
        begin
            if (sorted_p)
            begin
                if ($urandom_range(0, 99) >= 12)
                    acc = acc + $urandom_range(1, step_max[31:0]);
                if (acc > 64'hFFFF_FFFF)
                    acc = 64'hFFFF_FFFF;
                plan_cdf[j] = acc[PROB_BITS-1:0];
            end
            else
                plan_cdf[j] = $urandom();
        end
        if ($urandom_range(0, 1) == 1)
            plan_cdf[m-1] = '1;

        // energy column: rising, falling or random with extremes
        e_mode = $urandom_range(0, 3);
        e_step = 64'h200_0000 / m;
        ea = (e_mode == 2) ? 64'(24'hFFFFFF - $urandom_range(0, 24'h0F_FFFF))
                           : 64'($urandom_range(0, 24'h0F_FFFF));
        for (j = 0; j < m; j++)
        begin
            if (e_mode == 3)
            begin
                if ($urandom_range(0, 9) == 0)
                    plan_energy[j] = ($urandom_range(0, 1) == 1) ? '1 : '0;
                else
                    plan_energy[j] = ENERGY_BITS'($urandom());
            end
            else
            begin
                plan_energy[j] = ea[ENERGY_BITS-1:0];
                delta = 64'($urandom_range(0, e_step[31:0]));
                if (e_mode == 2)
                    ea = (delta > ea) ? 64'd0 : ea - delta;
                else
                    ea = (ea + delta > 64'hFF_FFFF) ? 64'hFF_FFFF : ea + delta;
            end
        end

        // load the plan, with stray writes above it
        reversed = ($urandom_range(0, 3) == 0);
        for (j = 0; j < m; j++)
        begin
            k = reversed ? m - 1 - j : j;
            idle_gap();
            issue_beat(icdf_pkg::FUNC_LOAD, ADDR_BITS'(k), plan_energy[k], plan_cdf[k],
                       $urandom(), 1'b0, '0);
            if (m < TABLE_DEPTH && $urandom_range(0, 9) == 0)
            begin
                idle_gap();
                issue_beat(icdf_pkg::FUNC_LOAD, ADDR_BITS'($urandom_range(m, TABLE_DEPTH - 1)),
                           ENERGY_BITS'($urandom()), $urandom(), $urandom(), 1'b0, '0);
            end
        end

        // draws, aimed mostly inside the loaded intervals
        reach = (scan_limit() < m) ? scan_limit() : m;
        for (k = $urandom_range(6, 30); k > 0; k--)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                idle_gap();
                issue_beat(icdf_pkg::FUNC_LOAD, ADDR_BITS'($urandom_range(0, m - 1)),
                           ENERGY_BITS'($urandom()), $urandom(), $urandom(), 1'b0, '0);
            end
            j = $urandom_range(0, m - 1);
            hi = bin_cdf[j];
            if (j == 0)
                lo = '0;
            else if (bin_cdf[j-1] < hi)
                lo = bin_cdf[j-1] + 1'b1;
            else
                lo = hi;
            r = $urandom_range(0, 99);
            if (r < 45)
                u = $urandom_range(lo, hi);
            else if (r < 60)
                u = hi;
            else if (r < 70)
                u = '0;
            else if (r < 80)
                u = '1;
            else
                u = $urandom();
            // keep the search inside loaded entries
            if (!draw_is_safe(u))
            begin
                top = '0;
                for (j = 0; j < reach; j++)
                    if (bin_cdf[j] > top)
                        top = bin_cdf[j];
                u = $urandom_range(0, top);
            end
            idle_gap();
            issue_beat(icdf_pkg::FUNC_SAMPLE, ADDR_BITS'($urandom()), ENERGY_BITS'($urandom()),
                       $urandom(), u, 1'b0, '0);
        end
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_draws.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d with no draw outstanding: energy=%h found=%b",
                             results_seen, energy, found);
            end
            else
            begin
                got_want = pending_draws.pop_front();
                if (energy !== got_want.energy || found !== got_want.found)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d mismatch: energy exp %h got %h, %s %b got %b",
                                 results_seen, got_want.energy, energy, "found exp",
                                 got_want.found, found);
                end
            end
        end
    end

    initial
    begin
        int target;
        int phase_pct [3];
        phase_pct = '{13, 88, 0};
        mismatches = 0;
        beats_sent = 0;
        loads_sent = 0;
        draws_sent = 0;
        hits_predicted = 0;
        misses_predicted = 0;
        depth_writes = 0;
        results_seen = 0;
        cycle_count = 0;
        scan_count = icdf_pkg::ENTRIES_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            bin_energy[i] = '0;
            bin_cdf[i] = '0;
            bin_loaded[i] = 1'b0;
        end
        rst_n = 1'b0;
        start = 1'b0;
        func = icdf_pkg::FUNC_LOAD;
        entry_index = '0;
        entry_energy = '0;
        entry_cumulative = '0;
        uniform_value = '0;
        entries_in_use_we = 1'b0;
        entries_in_use_wdata = '0;

        // Hold reset, release on a falling edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows
        send_idle_pct = phase_pct[0];
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            case (DIRECTED[i].kind)
                ROW_DEPTH:
                    write_depth(DIRECTED[i].arg[COUNT_BITS-1:0]);
                ROW_LOAD:
                begin
                    idle_gap();
                    issue_beat(icdf_pkg::FUNC_LOAD, DIRECTED[i].idx, DIRECTED[i].e,
                               DIRECTED[i].p, $urandom(), 1'b0, '0);
                end
                default:
                begin
                    idle_gap();
                    issue_beat(icdf_pkg::FUNC_SAMPLE, ADDR_BITS'($urandom()),
                               ENERGY_BITS'($urandom()), $urandom(),
                               DIRECTED[i].arg, DIRECTED[i].typed, DIRECTED[i].want);
                end
            endcase
        end

        // Random episodes under three sender gap rates
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = phase_pct[ph];
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
                run_episode();
        end

        // Drain and settle
        @(negedge clk);
        start <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        mismatches = mismatches + pending_draws.size();

        $display("Covered %0d table loads and %0d draws (%0d hits, %0d misses)",
                 loads_sent, draws_sent, hits_predicted, misses_predicted);
        $display("over %0d depth writes, sender gaps of 13, 88 and 0 percent; %0d mismatches",
                 depth_writes, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
